// ===== design/dvg_pkg.sv =====
// ----------------------------------------------------------------------------
// dvg_pkg
// Shared types and constants for the dithered vertical gradient generator:
// coordinate and pixel items, register indexes and hash constants.
// ----------------------------------------------------------------------------
package dvg_pkg;

    // coordinate and channel widths
    localparam int COORD_WIDTH = 12;
    localparam int CHAN_W      = 8;
    localparam int NUM_CH      = 3;
    localparam int COLOR_W     = CHAN_W * NUM_CH;
    localparam int HEIGHT_W    = 13;
    localparam int FRAC_W      = 24;

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = COLOR_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_TOP_COLOR    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_BOTTOM_COLOR = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_LEVEL  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = CFG_INDEX_W'(3);

    // register reset values
    localparam logic [COLOR_W-1:0]  COLOR_RESET  = '0;
    localparam logic [CHAN_W-1:0]   ALPHA_RESET  = 8'd128;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1;

    // coordinate hash
    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
    localparam int          HASH_SHIFT_A = 13;
    localparam int          HASH_SHIFT_B = 16;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] col;
        logic [COORD_WIDTH-1:0] row;
    } coord_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } pixel_t;

endpackage

// ===== design/dithered_vertical_gradient_generator.sv =====
// ----------------------------------------------------------------------------
// dithered_vertical_gradient_generator
// Pixel source: blends top and bottom colors over the image height, adds
// per-pixel hash noise as dither, rounds and clamps each channel.
//
//   channel   signals                            dir  notes
//   coord     start, busy, coord                 in   item taken on start & !busy
//   result    result_valid, result               out  one-cycle strobe, no stall
//   config    cfg_valid, cfg_ready, cfg_index,   in   write on valid & ready
//             cfg_data
//
// A new item can enter every cycle; busy is never raised and cfg_ready is
// always high. The pipeline has, in order:
// one stage per quotient bit of row * 2^24 / (height - 1), one multiply
// stage, eight stages of the per-channel remainder divide, one output stage.
// Reset clears valid bits and loads the configuration reset values; no clearing pass is needed.
// The result side cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module dithered_vertical_gradient_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  dvg_pkg::coord_t                     coord,
    output logic                                result_valid,
    output dvg_pkg::pixel_t                     result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dvg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dvg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW     = dvg_pkg::COORD_WIDTH;
    localparam int CHW    = dvg_pkg::CHAN_W;
    localparam int NCH    = dvg_pkg::NUM_CH;
    localparam int FW     = dvg_pkg::FRAC_W;
    localparam int DW     = dvg_pkg::HEIGHT_W;
    localparam int NUM_W  = CW + FW;
    // quotient cap: beyond 2^(CHW+1+FW) any nonzero slope saturates anyway
    localparam int QS_W   = CHW + 1 + FW;
    localparam int QX_W   = (NUM_W > QS_W) ? NUM_W : QS_W + 1;
    localparam int PROD_W = (CHW + 1) + (QS_W + 1);
    localparam int SUM_W  = PROD_W + 1;
    localparam int NR_W   = CHW + DW;
    localparam int EDIV   = CHW;

    // configuration registers
    logic [dvg_pkg::COLOR_W-1:0]  top_color_reg;
    logic [dvg_pkg::COLOR_W-1:0]  bottom_color_reg;
    logic [CHW-1:0]               alpha_level_reg;
    logic [DW-1:0]                image_height_reg;

    logic                         accept;
    logic [DW-1:0]                div_d;
    logic                         height_flat;

    // row divider stages
    logic                         yd_valid_reg [NUM_W];
    logic [DW-1:0]                yd_rem_reg   [NUM_W];
    logic [NUM_W-1:0]             yd_quo_reg   [NUM_W];
    logic [CW-1:0]                yd_col_reg   [NUM_W];
    logic [CW-1:0]                yd_row_reg   [NUM_W];
    logic [DW-1:0]                yd_rem_next  [NUM_W];
    logic [NUM_W-1:0]             yd_quo_next  [NUM_W];
    logic [CW-1:0]                yd_col_next  [NUM_W];
    logic [CW-1:0]                yd_row_next  [NUM_W];

    // multiply stage
    logic                         m_valid_reg;
    logic signed [PROD_W-1:0]     m_prod_reg  [NCH];
    logic [NR_W-1:0]              m_nr_reg    [NCH];
    logic                         m_neg_reg   [NCH];
    logic [31:0]                  m_hx_reg;
    logic [31:0]                  m_hy_reg;
    logic signed [PROD_W-1:0]     m_prod_next [NCH];
    logic [NR_W-1:0]              m_nr_next   [NCH];
    logic                         m_neg_next  [NCH];
    logic [31:0]                  m_hx_next;
    logic [31:0]                  m_hy_next;

    // per-channel remainder divide stages
    logic                         e_valid_reg [EDIV];
    logic [DW-1:0]                e_rem_reg   [EDIV][NCH];
    logic [EDIV-1:0]              e_uq_reg    [EDIV][NCH];
    logic [EDIV-1:0]              e_low_reg   [EDIV][NCH];
    logic                         e_neg_reg   [EDIV][NCH];
    logic signed [SUM_W-1:0]      e_base_reg  [EDIV][NCH];
    logic [31:0]                  e_h_reg     [EDIV];
    logic [DW-1:0]                e_rem_next  [EDIV][NCH];
    logic [EDIV-1:0]              e_uq_next   [EDIV][NCH];
    logic [EDIV-1:0]              e_low_next  [EDIV][NCH];
    logic                         e_neg_next  [EDIV][NCH];
    logic signed [SUM_W-1:0]      e_base_next [EDIV][NCH];
    logic [31:0]                  e_h_next    [EDIV];

    // output stage
    logic                         result_valid_reg;
    dvg_pkg::pixel_t              result_reg;
    dvg_pkg::pixel_t              result_next;

    // handshake
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    // divisor is height minus one; a height of zero or one gives a flat image
    assign div_d       = image_height_reg - DW'(1);
    assign height_flat = (image_height_reg[DW-1:1] == '0);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_color_reg    <= dvg_pkg::COLOR_RESET;
            bottom_color_reg <= dvg_pkg::COLOR_RESET;
            alpha_level_reg  <= dvg_pkg::ALPHA_RESET;
            image_height_reg <= dvg_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dvg_pkg::CFG_TOP_COLOR:    top_color_reg    <= cfg_data;
                dvg_pkg::CFG_BOTTOM_COLOR: bottom_color_reg <= cfg_data;
                dvg_pkg::CFG_ALPHA_LEVEL:  alpha_level_reg  <= cfg_data[CHW-1:0];
                dvg_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // row * 2^24 / (height - 1), one quotient bit per stage
    always_comb
    begin
        for (int i = 0; i < NUM_W; i++)
        begin
            logic [DW-1:0]    rem_in;
            logic [NUM_W-1:0] quo_in;
            logic [NUM_W-1:0] num;
            logic [DW:0]      trial;
            logic             ge;
            if (i == 0)
            begin
                rem_in         = '0;
                quo_in         = '0;
                yd_col_next[i] = coord.col;
                yd_row_next[i] = coord.row;
            end
            else
            begin
                rem_in         = yd_rem_reg[i-1];
                quo_in         = yd_quo_reg[i-1];
                yd_col_next[i] = yd_col_reg[i-1];
                yd_row_next[i] = yd_row_reg[i-1];
            end
            num   = {yd_row_next[i], {FW{1'b0}}};
            trial = {rem_in, num[NUM_W-1-i]};
            ge    = (trial >= {1'b0, div_d});
            yd_rem_next[i] = ge ? DW'(trial - {1'b0, div_d}) : trial[DW-1:0];
            yd_quo_next[i] = {quo_in[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_W; i++)
            begin
                yd_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            yd_valid_reg[0] <= accept;
            for (int i = 1; i < NUM_W; i++)
            begin
                yd_valid_reg[i] <= yd_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_W; i++)
        begin
            yd_rem_reg[i] <= yd_rem_next[i];
            yd_quo_reg[i] <= yd_quo_next[i];
            yd_col_reg[i] <= yd_col_next[i];
            yd_row_reg[i] <= yd_row_next[i];
        end
    end

    // slope times quotient, slope times remainder, first hash products
    always_comb
    begin
        logic [QX_W-1:0]          q_ext;
        logic                     q_big;
        logic [QS_W-1:0]          q_sat;
        logic [DW-1:0]            r_sat;
        logic signed [PROD_W-1:0] q_wide;
        q_ext  = QX_W'(yd_quo_reg[NUM_W-1]);
        q_big  = |q_ext[QX_W-1:QS_W];
        q_sat  = height_flat ? '0 : (q_big ? {QS_W{1'b1}} : q_ext[QS_W-1:0]);
        r_sat  = (height_flat || q_big) ? '0 : yd_rem_reg[NUM_W-1];
        q_wide = $signed({{(PROD_W-QS_W){1'b0}}, q_sat});
        for (int c = 0; c < NCH; c++)
        begin
            logic [CHW-1:0]           tc;
            logic [CHW-1:0]           bc;
            logic signed [CHW:0]      d;
            logic [CHW-1:0]           d_abs;
            logic signed [PROD_W-1:0] d_wide;
            tc     = top_color_reg[dvg_pkg::COLOR_W-1-CHW*c -: CHW];
            bc     = bottom_color_reg[dvg_pkg::COLOR_W-1-CHW*c -: CHW];
            d      = $signed({1'b0, bc}) - $signed({1'b0, tc});
            d_abs  = d[CHW] ? CHW'(-d) : d[CHW-1:0];
            d_wide = PROD_W'(d);
            m_prod_next[c] = PROD_W'(d_wide * q_wide);
            m_nr_next[c]   = NR_W'(NR_W'(d_abs) * NR_W'(r_sat));
            m_neg_next[c]  = d[CHW];
        end
        m_hx_next = 32'(32'(yd_col_reg[NUM_W-1]) * dvg_pkg::HASH_MUL_X);
        m_hy_next = 32'(32'(yd_row_reg[NUM_W-1]) * dvg_pkg::HASH_MUL_Y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= yd_valid_reg[NUM_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NCH; c++)
        begin
            m_prod_reg[c] <= m_prod_next[c];
            m_nr_reg[c]   <= m_nr_next[c];
            m_neg_reg[c]  <= m_neg_next[c];
        end
        m_hx_reg <= m_hx_next;
        m_hy_reg <= m_hy_next;
    end

    // |slope| * remainder / (height - 1), eight quotient bits per channel;
    // the hash finishes alongside
    always_comb
    begin
        for (int k = 0; k < EDIV; k++)
        begin
            logic [31:0] h_in;
            logic [31:0] h_sum;
            if (k == 0)
            begin
                h_in = '0;
            end
            else
            begin
                h_in = e_h_reg[k-1];
            end
            h_sum = m_hx_reg + m_hy_reg;
            if (k == 0)
            begin
                e_h_next[k] = h_sum ^ (h_sum >> dvg_pkg::HASH_SHIFT_A);
            end
            else if (k == 1)
            begin
                e_h_next[k] = 32'(h_in * dvg_pkg::HASH_MUL_MIX);
            end
            else if (k == 2)
            begin
                e_h_next[k] = h_in ^ (h_in >> dvg_pkg::HASH_SHIFT_B);
            end
            else
            begin
                e_h_next[k] = h_in;
            end

            for (int c = 0; c < NCH; c++)
            begin
                logic [DW-1:0]   rem_in;
                logic [EDIV-1:0] uq_in;
                logic [DW:0]     trial;
                logic            ge;
                if (k == 0)
                begin
                    rem_in            = m_nr_reg[c][NR_W-1:CHW];
                    uq_in             = '0;
                    e_low_next[k][c]  = m_nr_reg[c][CHW-1:0];
                    e_neg_next[k][c]  = m_neg_reg[c];
                    e_base_next[k][c] = $signed({{(SUM_W-CHW-FW){1'b0}},
                                                 top_color_reg[dvg_pkg::COLOR_W-1-CHW*c -: CHW],
                                                 {FW{1'b0}}})
                                        + SUM_W'(m_prod_reg[c]);
                end
                else
                begin
                    rem_in            = e_rem_reg[k-1][c];
                    uq_in             = e_uq_reg[k-1][c];
                    e_low_next[k][c]  = e_low_reg[k-1][c];
                    e_neg_next[k][c]  = e_neg_reg[k-1][c];
                    e_base_next[k][c] = e_base_reg[k-1][c];
                end
                trial = {rem_in, e_low_next[k][c][EDIV-1-k]};
                ge    = (trial >= {1'b0, div_d});
                e_rem_next[k][c] = ge ? DW'(trial - {1'b0, div_d}) : trial[DW-1:0];
                e_uq_next[k][c]  = {uq_in[EDIV-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < EDIV; k++)
            begin
                e_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            e_valid_reg[0] <= m_valid_reg;
            for (int k = 1; k < EDIV; k++)
            begin
                e_valid_reg[k] <= e_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < EDIV; k++)
        begin
            e_h_reg[k] <= e_h_next[k];
            for (int c = 0; c < NCH; c++)
            begin
                e_rem_reg[k][c]  <= e_rem_next[k][c];
                e_uq_reg[k][c]   <= e_uq_next[k][c];
                e_low_reg[k][c]  <= e_low_next[k][c];
                e_neg_reg[k][c]  <= e_neg_next[k][c];
                e_base_reg[k][c] <= e_base_next[k][c];
            end
        end
    end

    // floor correction, noise add, round down and clamp
    always_comb
    begin
        logic [CHW-1:0]          chan [NCH];
        logic signed [SUM_W-1:0] noise_w;
        noise_w = $signed({{(SUM_W-FW){1'b0}}, e_h_reg[EDIV-1][FW-1:0]});
        for (int c = 0; c < NCH; c++)
        begin
            logic                    rem_nz;
            logic signed [CHW+1:0]   uq_s;
            logic signed [CHW+1:0]   e_val;
            logic signed [SUM_W-1:0] sum;
            rem_nz = |e_rem_reg[EDIV-1][c];
            uq_s   = $signed({2'b00, e_uq_reg[EDIV-1][c]});
            if (height_flat)
            begin
                e_val = '0;
            end
            else if (e_neg_reg[EDIV-1][c])
            begin
                e_val = -uq_s - $signed({{(CHW+1){1'b0}}, rem_nz});
            end
            else
            begin
                e_val = uq_s;
            end
            sum = e_base_reg[EDIV-1][c] + SUM_W'(e_val) + noise_w;
            if (sum[SUM_W-1])
            begin
                chan[c] = '0;
            end
            else if (|sum[SUM_W-2:FW+CHW])
            begin
                chan[c] = {CHW{1'b1}};
            end
            else
            begin
                chan[c] = sum[FW+CHW-1:FW];
            end
        end
        result_next.red   = chan[0];
        result_next.green = chan[1];
        result_next.blue  = chan[2];
        result_next.alpha = alpha_level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= e_valid_reg[EDIV-1];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
